[rtl/eab_pkg.sv]
// Shared constants and helpers for the Euler-angle to basis-vector block.
// Holds default parameter values, CORDIC working widths and the arctangent table.
// No dependencies.
package eab_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 18;

  // width of each angle field on the input channel
  localparam int ANGLE_IN_W = 16;

  // CORDIC datapath: x/y carry 30 fractional bits, z is a fraction of a turn
  localparam int WORK_FRAC = 30;
  localparam int XY_W      = 34;
  localparam int Z_W       = 33;
  localparam int Z_FRAC    = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // atan(2^-i) as a fraction of a turn, 32 fractional bits
  function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = 33'sh020000000;
      5'd1:  r = 33'sh012E4051E;
      5'd2:  r = 33'sh009FB385B;
      5'd3:  r = 33'sh0051111D4;
      5'd4:  r = 33'sh0028B0D43;
      5'd5:  r = 33'sh00145D7E1;
      5'd6:  r = 33'sh000A2F61E;
      5'd7:  r = 33'sh000517C55;
      5'd8:  r = 33'sh00028BE53;
      5'd9:  r = 33'sh000145F2F;
      5'd10: r = 33'sh0000A2F98;
      5'd11: r = 33'sh0000517CC;
      5'd12: r = 33'sh000028BE6;
      5'd13: r = 33'sh0000145F3;
      5'd14: r = 33'sh00000A2FA;
      5'd15: r = 33'sh00000517D;
      5'd16: r = 33'sh0000028BE;
      5'd17: r = 33'sh00000145F;
      5'd18: r = 33'sh000000A30;
      5'd19: r = 33'sh000000518;
      5'd20: r = 33'sh00000028C;
      5'd21: r = 33'sh000000146;
      5'd22: r = 33'sh0000000A3;
      5'd23: r = 33'sh000000051;
      5'd24: r = 33'sh000000029;
      5'd25: r = 33'sh000000014;
      5'd26: r = 33'sh00000000A;
      5'd27: r = 33'sh000000005;
      5'd28: r = 33'sh000000003;
      5'd29: r = 33'sh000000001;
      5'd30: r = 33'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/eab_if.sv]
// Handshake channels of the Euler-angle to basis-vector block.
// Input channel carries three angles, output channel nine vector components.
// Depends on eab_pkg.
interface eab_in_if;
  logic                             valid;
  logic                             ready;
  logic [eab_pkg::ANGLE_IN_W-1:0]   pitch_angle;
  logic [eab_pkg::ANGLE_IN_W-1:0]   yaw_angle;
  logic [eab_pkg::ANGLE_IN_W-1:0]   roll_angle;

  modport source (output valid, pitch_angle, yaw_angle, roll_angle, input ready);
  modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

interface eab_out_if #(
  parameter int FRAC_BITS = eab_pkg::FRAC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] forward_x;
  logic signed [FRAC_BITS+1:0] forward_y;
  logic signed [FRAC_BITS+1:0] forward_z;
  logic signed [FRAC_BITS+1:0] right_x;
  logic signed [FRAC_BITS+1:0] right_y;
  logic signed [FRAC_BITS+1:0] right_z;
  logic signed [FRAC_BITS+1:0] up_x;
  logic signed [FRAC_BITS+1:0] up_y;
  logic signed [FRAC_BITS+1:0] up_z;

  modport source (output valid, forward_x, forward_y, forward_z, right_x, right_y,
                  right_z, up_x, up_y, up_z, input ready);
  modport sink   (input valid, forward_x, forward_y, forward_z, right_x, right_y,
                  right_z, up_x, up_y, up_z, output ready);
endinterface

[rtl/eab_cordic.sv]
// One pipelined CORDIC lane: binary angle in, rounded sine and cosine out.
// One register stage per iteration plus a load stage; advances on en.
// Depends on eab_pkg.
module eab_cordic #(
  parameter int ANGLE_BITS   = eab_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS    = eab_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = eab_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [eab_pkg::ANGLE_IN_W-1:0]   angle,
  output logic signed [FRAC_BITS+1:0]      sin_val,
  output logic signed [FRAC_BITS+1:0]      cos_val
);

  localparam int N  = CORDIC_STEPS;
  localparam int XW = eab_pkg::XY_W;
  localparam int ZW = eab_pkg::Z_W;
  localparam int SH = eab_pkg::WORK_FRAC - FRAC_BITS;
  localparam int OW = FRAC_BITS + 2;
  localparam int PADW = eab_pkg::Z_FRAC - ANGLE_BITS;

  logic [ANGLE_BITS-1:0]  a;
  logic signed [XW-1:0]   x_r [0:N];
  logic signed [XW-1:0]   y_r [0:N];
  logic signed [ZW-1:0]   z_r [0:N];
  logic [1:0]             quad_r [0:N];
  logic signed [XW-1:0]   cs;
  logic signed [XW-1:0]   sn;

  assign a = ANGLE_BITS'(angle);

  // load: residue within the quadrant becomes the starting angle
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= eab_pkg::CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= ZW'({a[ANGLE_BITS-3:0], PADW'(0)});
      quad_r[0] <= a[ANGLE_BITS-1 -: 2];
    end
  end

  // rotation iterations, one per stage
  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        quad_r[i+1] <= quad_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - eab_pkg::atan_turn(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + eab_pkg::atan_turn(5'(i));
        end
      end
    end
  end

  // apply the quadrant exactly
  always_comb begin
    case (quad_r[N])
      2'd0: begin cs = x_r[N];  sn = y_r[N];  end
      2'd1: begin cs = -y_r[N]; sn = x_r[N];  end
      2'd2: begin cs = -x_r[N]; sn = -y_r[N]; end
      default: begin cs = y_r[N]; sn = -x_r[N]; end
    endcase
  end

  // round to the output precision and clamp to plus or minus one
  function automatic logic signed [OW-1:0] round_sat(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    logic signed [XW:0] rnd;
    logic signed [XW:0] one;
    logic signed [XW:0] r;
    t   = {v[XW-1], v};
    rnd = (XW+1)'(1) << (SH - 1);
    one = (XW+1)'(1) << FRAC_BITS;
    if (SH > 0) begin
      t = (t + rnd) >>> SH;
    end
    if (t > one) begin
      r = one;
    end else if (t < -one) begin
      r = -one;
    end else begin
      r = t;
    end
    return OW'(r);
  endfunction

  assign cos_val = round_sat(cs);
  assign sin_val = round_sat(sn);

endmodule

[rtl/eab_queue.sv]
// Small first-in first-out queue between the trig front and the product back.
// Register storage, one push and one pop per cycle.
// Depends on eab_pkg for the default depth.
module eab_queue #(
  parameter int W     = 8,
  parameter int DEPTH = eab_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         rvalid,
  output logic [W-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full   = (count == CW'(DEPTH));
  assign rvalid = (count != '0);
  assign rdata  = mem[rd_ptr];

  // store an item on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/eab_back.sv]
// Product back end: combines sines and cosines into the three basis vectors.
// Three stages: first products, roll products, sums with clamp (output register).
// Depends on eab_pkg and eab_if.
module eab_back #(
  parameter int FRAC_BITS = eab_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [6*(FRAC_BITS+2)-1:0]   q_data,
  output logic                         q_pop,
  eab_out_if.source                    out_ch
);

  localparam int OW = FRAC_BITS + 2;
  localparam int PW = 2 * OW;

  typedef logic signed [OW-1:0] val_t;

  val_t sp, cp, sy, cy, sr, cr;
  logic [2:0] vld;
  logic       adv;

  val_t spcy, spsy, cpcy, cpsy, crsy, crcy, srsy, srcy, srcp, crcp, nsp, sr1, cr1;
  val_t srspcy, srspsy, crspcy, crspsy;
  val_t cpcy2, cpsy2, crsy2, crcy2, srsy2, srcy2, srcp2, crcp2, nsp2;

  assign sp = q_data[0*OW +: OW];
  assign cp = q_data[1*OW +: OW];
  assign sy = q_data[2*OW +: OW];
  assign cy = q_data[3*OW +: OW];
  assign sr = q_data[4*OW +: OW];
  assign cr = q_data[5*OW +: OW];

  assign adv          = !vld[2] || out_ch.ready;
  assign q_pop        = q_valid && adv;
  assign out_ch.valid = vld[2];

  // exact product rounded back to the working precision
  function automatic val_t fmul(input val_t a, input val_t b);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] rnd;
    rnd = PW'(1) << (FRAC_BITS - 1);
    p   = PW'(a) * PW'(b);
    p   = (p + rnd) >>> FRAC_BITS;
    return OW'(p);
  endfunction

  function automatic val_t sat(input logic signed [OW:0] v);
    logic signed [OW:0] one;
    logic signed [OW:0] r;
    one = (OW+1)'(1) << FRAC_BITS;
    if (v > one) begin
      r = one;
    end else if (v < -one) begin
      r = -one;
    end else begin
      r = v;
    end
    return OW'(r);
  endfunction

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], q_valid};
    end
  end

  // stage 1: products of two angles
  always_ff @(posedge clk) begin
    if (adv) begin
      spcy <= fmul(sp, cy);
      spsy <= fmul(sp, sy);
      cpcy <= fmul(cp, cy);
      cpsy <= fmul(cp, sy);
      crsy <= fmul(cr, sy);
      crcy <= fmul(cr, cy);
      srsy <= fmul(sr, sy);
      srcy <= fmul(sr, cy);
      srcp <= fmul(sr, cp);
      crcp <= fmul(cr, cp);
      nsp  <= -sp;
      sr1  <= sr;
      cr1  <= cr;
    end
  end

  // stage 2: roll terms of the triple products
  always_ff @(posedge clk) begin
    if (adv) begin
      srspcy <= fmul(sr1, spcy);
      srspsy <= fmul(sr1, spsy);
      crspcy <= fmul(cr1, spcy);
      crspsy <= fmul(cr1, spsy);
      cpcy2  <= cpcy;
      cpsy2  <= cpsy;
      crsy2  <= crsy;
      crcy2  <= crcy;
      srsy2  <= srsy;
      srcy2  <= srcy;
      srcp2  <= srcp;
      crcp2  <= crcp;
      nsp2   <= nsp;
    end
  end

  // stage 3: sums, clamp and hold for the receiver
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.forward_x <= sat((OW+1)'(cpcy2));
      out_ch.forward_y <= sat((OW+1)'(cpsy2));
      out_ch.forward_z <= sat((OW+1)'(nsp2));
      out_ch.right_x   <= sat(-(OW+1)'(srspcy) + (OW+1)'(crsy2));
      out_ch.right_y   <= sat(-(OW+1)'(srspsy) - (OW+1)'(crcy2));
      out_ch.right_z   <= sat(-(OW+1)'(srcp2));
      out_ch.up_x      <= sat((OW+1)'(crspcy) + (OW+1)'(srsy2));
      out_ch.up_y      <= sat((OW+1)'(crspsy) - (OW+1)'(srcy2));
      out_ch.up_z      <= sat((OW+1)'(crcp2));
    end
  end

endmodule

[rtl/euler_angles_to_basis_vectors_core.sv]
// Top level of the Euler-angle to basis-vector block.
// Front: three CORDIC lanes; queue; back: product and sum pipeline.
// Depends on eab_pkg, eab_if, eab_cordic, eab_queue and eab_back.
//
// Usage:
//   in_ch carries pitch, yaw and roll as binary angles (a full turn wraps).
//   out_ch carries forward, right and up vectors, each component signed
//   with FRAC_BITS fractional bits, clamped to plus or minus one.
//   An item is taken when valid and ready are both high on a channel.
// Timing:
//   One item per cycle sustained while out_ch is not stalled. From acceptance
//   to out_ch.valid an item passes a load stage and one stage per CORDIC
//   iteration, then the queue and three product stages.
// Reset:
//   rst clears all valid bits and the queue; no item is in flight afterwards.
// Stall:
//   A stalled receiver freezes the back pipeline with its result held on
//   out_ch; the queue then fills, and only when it is full and the last
//   CORDIC stage holds an item does the front freeze and drop in_ch.ready.
module euler_angles_to_basis_vectors_core #(
  parameter int ANGLE_BITS   = eab_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS    = eab_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = eab_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  eab_in_if.sink     in_ch,
  eab_out_if.source  out_ch
);

  localparam int N  = CORDIC_STEPS;
  localparam int OW = FRAC_BITS + 2;
  localparam int QW = 6 * OW;

  logic [N:0]           vld;
  logic                 fadv;
  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  logic [QW-1:0]        q_rdata;
  logic signed [OW-1:0] sp, cp, sy, cy, sr, cr;

  // front advances unless its last stage holds an item the queue cannot take
  assign fadv        = !vld[N] || !q_full;
  assign q_push      = vld[N] && !q_full;
  assign in_ch.ready = fadv;

  // front valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (fadv) begin
      vld <= {vld[N-1:0], in_ch.valid};
    end
  end

  eab_cordic #(
    .ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_pitch (
    .clk(clk), .en(fadv), .angle(in_ch.pitch_angle), .sin_val(sp), .cos_val(cp)
  );

  eab_cordic #(
    .ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_yaw (
    .clk(clk), .en(fadv), .angle(in_ch.yaw_angle), .sin_val(sy), .cos_val(cy)
  );

  eab_cordic #(
    .ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_roll (
    .clk(clk), .en(fadv), .angle(in_ch.roll_angle), .sin_val(sr), .cos_val(cr)
  );

  eab_queue #(
    .W(QW), .DEPTH(eab_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata({cr, sr, cy, sy, cp, sp}),
    .full(q_full), .pop(q_pop), .rvalid(q_valid), .rdata(q_rdata)
  );

  eab_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_rdata), .q_pop(q_pop),
    .out_ch(out_ch)
  );

  // an accepted item enters the first front stage
  a_load: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> vld[0])
    else $error("accepted item did not enter the front pipeline");

  // a finished front item is held while the queue is full
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[N] && !fadv) |=> vld[N])
    else $error("front item lost while the queue was full");

  // a queued item stays until the back takes it
  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_pop) |=> q_valid)
    else $error("queued item lost without a pop");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for euler_angles_to_basis_vectors_core.
// Predicts the forward, right and up vectors with a bit-exact CORDIC model
// and compares each output item. Depends on eab_pkg, eab_if and the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB     = eab_pkg::FRAC_BITS_DEF;
  localparam int AB     = eab_pkg::ANGLE_BITS_DEF;
  localparam int STEPS  = eab_pkg::CORDIC_STEPS_DEF;
  localparam int OUT_W  = FB + 2;
  localparam int N_RAND = 1130;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [OUT_W-1:0] comp_t;
  typedef struct packed {
    comp_t fx, fy, fz, rx, ry, rz, ux, uy, uz;
  } basis_t;

  // arctangent steps, a fraction of a turn with 32 fractional bits
  localparam longint ATAN_TURNS [32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000};

  // rounding shift with half an LSB added
  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    longint one;
    one = 64'sd1 <<< FB;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, FB);
  endfunction

  // CORDIC sine and cosine of a binary angle
  function automatic void angle_sin_cos(input logic [15:0] ang, output longint sn,
                                        output longint cs);
    longint x, y, z, dx, dy, rc, rs;
    logic [1:0] quad;
    logic [AB-1:0] a;
    a = ang[AB-1:0];
    quad = a[AB-1 -: 2];
    z = longint'(a[AB-3:0]) <<< (32 - AB);
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[i % 32];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[i % 32];
      end
    end
    case (quad)
      2'd0: begin rc = x;  rs = y;  end
      2'd1: begin rc = -y; rs = x;  end
      2'd2: begin rc = -x; rs = -y; end
      default: begin rc = y; rs = -x; end
    endcase
    cs = clamp_unit(rnd_shift(rc, eab_pkg::WORK_FRAC - FB));
    sn = clamp_unit(rnd_shift(rs, eab_pkg::WORK_FRAC - FB));
  endfunction

  function automatic basis_t predict_basis(logic [15:0] p, logic [15:0] yw, logic [15:0] r);
    longint sp, cp, sy, cy, sr, cr, spcy, spsy;
    basis_t b;
    angle_sin_cos(p, sp, cp);
    angle_sin_cos(yw, sy, cy);
    angle_sin_cos(r, sr, cr);
    spcy = qmul(sp, cy);
    spsy = qmul(sp, sy);
    b.fx = comp_t'(clamp_unit(qmul(cp, cy)));
    b.fy = comp_t'(clamp_unit(qmul(cp, sy)));
    b.fz = comp_t'(clamp_unit(-sp));
    b.rx = comp_t'(clamp_unit(-qmul(sr, spcy) + qmul(cr, sy)));
    b.ry = comp_t'(clamp_unit(-qmul(sr, spsy) - qmul(cr, cy)));
    b.rz = comp_t'(clamp_unit(-qmul(sr, cp)));
    b.ux = comp_t'(clamp_unit(qmul(cr, spcy) + qmul(sr, sy)));
    b.uy = comp_t'(clamp_unit(qmul(cr, spsy) - qmul(sr, cy)));
    b.uz = comp_t'(clamp_unit(qmul(cr, cp)));
    return b;
  endfunction

  // holds expected vectors in order and compares arrivals
  class basis_board;
    basis_t pending[$];
    int errors;

    function void note_angles(logic [15:0] p, logic [15:0] yw, logic [15:0] r);
      pending.push_back(predict_basis(p, yw, r));
    endfunction

    function void check_vectors(basis_t got);
      basis_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output item %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        errors++;
        $display("%0t: mismatch exp fwd(%0d %0d %0d) rgt(%0d %0d %0d) up(%0d %0d %0d)",
                 $realtime, want.fx, want.fy, want.fz, want.rx, want.ry, want.rz,
                 want.ux, want.uy, want.uz);
        $display("%0t:          got fwd(%0d %0d %0d) rgt(%0d %0d %0d) up(%0d %0d %0d)",
                 $realtime, got.fx, got.fy, got.fz, got.rx, got.ry, got.rz,
                 got.ux, got.uy, got.uz);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycles = 0;
  basis_board board;
  bit sink_busy = 1'b1;

  eab_in_if  in_ch ();
  eab_out_if #(.FRAC_BITS(FB)) out_ch ();

  euler_angles_to_basis_vectors_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one item and hold it until taken
  task automatic send_angles(logic [15:0] p, logic [15:0] yw, logic [15:0] r);
    in_ch.valid <= 1'b1;
    in_ch.pitch_angle <= p;
    in_ch.yaw_angle <= yw;
    in_ch.roll_angle <= r;
    do @(posedge clk); while (!in_ch.ready);
    board.note_angles(p, yw, r);
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    if (n == 0) return;
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 2) - 1);
      1: return 16'(($urandom_range(0, 3) << 14));
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls, sample at the rising edge
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      int g;
      g = sink_busy ? gap_len() : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        board.check_vectors({out_ch.forward_x, out_ch.forward_y, out_ch.forward_z,
                             out_ch.right_x, out_ch.right_y, out_ch.right_z,
                             out_ch.up_x, out_ch.up_y, out_ch.up_z});
      @(negedge clk);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [15:0] corner [8];
    int drain;
    board = new();
    in_ch.valid = 1'b0;
    in_ch.pitch_angle = '0;
    in_ch.yaw_angle = '0;
    in_ch.roll_angle = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: quadrant boundaries, extremes and wrap-around
    corner = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF, 16'h2000,
               16'h7FFF};
    for (int i = 0; i < 8; i++)
      send_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
    send_angles(16'h5555, 16'hAAAA, 16'h1234);
    send_angles(16'hAAAA, 16'h5555, 16'hEDCB);
    for (int i = 0; i < 8; i++)
      send_angles(corner[(i + 1) % 8], corner[i], corner[(i + 6) % 8]);

    // random: stretches with and without gaps
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 2) begin
        // hold off until everything has drained
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
      end
      sink_busy = !((n / 150) % 3 == 1);
      if ((n / 150) % 3 != 1) idle_sender(gap_len());
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    in_ch.valid <= 1'b0;

    while (board.pending.size() != 0) @(negedge clk);
    drain = STEPS + 10;
    repeat (drain) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

[filelist.f]
rtl/eab_pkg.sv
rtl/eab_if.sv
rtl/eab_cordic.sv
rtl/eab_queue.sv
rtl/eab_back.sv
rtl/euler_angles_to_basis_vectors_core.sv
tb/sv/tb_top.sv
